>>> hdl/swk_pkg.sv
// Shared types and constants for the swerve wheel kinematics block.
// Used by every module under hdl; depends on nothing else.
`default_nettype none

package swk_pkg;

  localparam int QW        = 35;  // Q16 wheel component width
  localparam int L8W       = 27;  // Q8 wheel component width
  localparam int XW        = 45;  // CORDIC x/y width (Q24 plus growth)
  localparam int ZW        = 30;  // CORDIC angle accumulator width
  localparam int Z_BITS    = 20;  // accumulator fraction bits (degrees)
  localparam int SQW       = 56;  // square sum width
  localparam int SQ_STEPS  = SQW / 2;
  localparam int AW        = 34;  // angle arithmetic width
  localparam int DW        = 39;  // dividend width of the remainder-by-45 unit
  localparam int LOW       = 14;  // low angle bits kept beside the remainder unit
  localparam int MW        = 32;  // measured/target angle width
  localparam int TABLE_LEN = 24;

  localparam logic signed [17:0] COEF_103 = 18'sd67502;
  localparam logic signed [17:0] COEF_965 = 18'sd63273;
  localparam logic signed [17:0] COEF_026 = 18'sd17072;

  localparam logic [5:0] DIVISOR = 6'd45;

  localparam logic signed [ZW-1:0] QUARTER_TURN = 30'sd94371840;

  localparam logic signed [ZW-1:0] ATAN_Q20 [TABLE_LEN] = '{
    30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
    30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
    30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
    30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
    30'sd917,      30'sd458,      30'sd229,      30'sd115,
    30'sd57,       30'sd29,       30'sd14,       30'sd7
  };

  typedef struct packed {
    logic [1:0]           wheel;
    logic                 lock;
    logic signed [MW-1:0] meas;
  } swk_tag_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [SQW-1:0]       n;
    logic [SQW-1:0]       r;
    logic                 zero;
    swk_tag_t             tag;
  } swk_vec_t;

  typedef struct packed {
    logic [DW-1:0]  num;
    logic [5:0]     rem;
    logic           qbit;
    logic [LOW-1:0] lo;
    logic [15:0]    speed;
    swk_tag_t       tag;
  } swk_div_t;

endpackage

`default_nettype wire

>>> hdl/swk_vec_cell.sv
// One cell of the vector chain: a CORDIC micro-rotation below CORDIC_STEPS
// and one bit of the integer square root. Depends on swk_pkg.
`default_nettype none

module swk_vec_cell #(
  parameter int IDX          = 0,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire swk_pkg::swk_vec_t in_vec,
  output logic                  out_valid,
  output swk_pkg::swk_vec_t     out_vec
);

  localparam int TI = (IDX < swk_pkg::TABLE_LEN) ? IDX : swk_pkg::TABLE_LEN - 1;
  localparam logic [swk_pkg::SQW-1:0] BIT = swk_pkg::SQW'(1) << (swk_pkg::SQW - 2 - 2 * IDX);

  logic              valid_r;
  swk_pkg::swk_vec_t vec_r, vec_nxt;

  always_comb begin
    logic signed [swk_pkg::XW-1:0] xs, ys;
    logic [swk_pkg::SQW-1:0]       rb;
    vec_nxt = in_vec;
    xs      = $signed(in_vec.x) >>> IDX;
    ys      = $signed(in_vec.y) >>> IDX;
    rb      = in_vec.r + BIT;
    if (IDX < CORDIC_STEPS) begin
      if ($signed(in_vec.y) > 0) begin
        vec_nxt.x = $signed(in_vec.x) + ys;
        vec_nxt.y = $signed(in_vec.y) - xs;
        vec_nxt.z = $signed(in_vec.z) + swk_pkg::ATAN_Q20[TI];
      end else begin
        vec_nxt.x = $signed(in_vec.x) - ys;
        vec_nxt.y = $signed(in_vec.y) + xs;
        vec_nxt.z = $signed(in_vec.z) - swk_pkg::ATAN_Q20[TI];
      end
    end
    if (in_vec.n >= rb) begin
      vec_nxt.n = in_vec.n - rb;
      vec_nxt.r = (in_vec.r >> 1) + BIT;
    end else begin
      vec_nxt.r = in_vec.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;

endmodule

`default_nettype wire

>>> hdl/swk_div_cell.sv
// Remainder-by-45 unit: slice folding, reciprocal multiplication and the
// quotient parity over three register stages. Depends on swk_pkg.
`default_nettype none

module swk_div_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire swk_pkg::swk_div_t in_div,
  output logic                   out_valid,
  output swk_pkg::swk_div_t      out_div
);

  localparam int FW  = 14;  // folded dividend width
  localparam int PW  = 2 * FW;
  localparam int QBW = 9;
  localparam int RSH = 19;
  // ceil(2^19 / 45); the quotient is exact for every value below 2^14.
  localparam logic [FW-1:0] RECIP = 14'd11651;

  logic              v1_r, v2_r, v3_r;
  logic [FW-1:0]     fold_c, fold1_r, n2_r;
  logic [QBW-1:0]    q_c, q2_r;
  logic [5:0]        rem_c;
  swk_pkg::swk_div_t div1_r, div2_r, div3_r, div_nxt;

  // 2^12 is 1 modulo 45, so summing 12-bit slices keeps the remainder.
  assign fold_c = FW'(in_div.num[11:0]) + FW'(in_div.num[23:12]) +
                  FW'(in_div.num[35:24]) + FW'(in_div.num[swk_pkg::DW-1:36]);
  assign q_c    = QBW'((PW'(fold1_r) * PW'(RECIP)) >> RSH);
  assign rem_c  = 6'(n2_r - FW'(q2_r) * FW'(swk_pkg::DIVISOR));

  // The quotient has the parity of dividend minus remainder, as 45 is odd.
  always_comb begin
    div_nxt      = div2_r;
    div_nxt.rem  = rem_c;
    div_nxt.qbit = div2_r.num[0] ^ rem_c[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div1_r  <= in_div;
      fold1_r <= fold_c;
      div2_r  <= div1_r;
      n2_r    <= fold1_r;
      q2_r    <= q_c;
      div3_r  <= div_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_div   = div3_r;

endmodule

`default_nettype wire

>>> hdl/swk_front.sv
// Request holding, wheel sequencing and wheel vector front end: components,
// squares, square sum and CORDIC pre-rotation. Depends on swk_pkg.
`default_nettype none

module swk_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_mode,
  input  wire logic signed [15:0] in_vel_side,
  input  wire logic signed [15:0] in_vel_fwd,
  input  wire logic signed [15:0] in_vel_rot,
  input  wire logic signed [31:0] in_angle_front,
  input  wire logic signed [31:0] in_angle_left,
  input  wire logic signed [31:0] in_angle_right,
  input  wire logic signed [31:0] in_angle_rear,
  output logic                    vec_valid,
  output swk_pkg::swk_vec_t       vec
);

  localparam int QW  = swk_pkg::QW;
  localparam int L8W = swk_pkg::L8W;
  localparam int XW  = swk_pkg::XW;

  logic       busy_r, busy_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       issue, issue_last, accept;

  logic                mode_h_r;
  logic signed [15:0]  side_h_r, fwd_h_r, rot_h_r;
  logic signed [31:0]  meas_h_r [4];

  logic signed [17:0]  coef_l, coef_f;
  logic signed [33:0]  pl, pf;
  swk_pkg::swk_tag_t   tag_c;

  logic                v1_r, v2_r, v3_r, v4_r;
  logic signed [QW-1:0]  lq1_r, fq1_r;
  logic signed [QW-1:0]  lr, fr;
  logic signed [L8W-1:0] l82_r, f82_r, l83_r, f83_r;
  logic signed [2*L8W-1:0] psl, psf;
  logic [2*L8W-1:0]      sql3_r, sqf3_r;
  swk_pkg::swk_tag_t     tag1_r, tag2_r, tag3_r;
  swk_pkg::swk_vec_t     vec_nxt, vec_r;

  assign issue      = busy_r && en;
  assign issue_last = issue && (cnt_r == 2'd3);
  assign in_stall   = busy_r && !issue_last;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (issue_last) begin
      busy_nxt = 1'b0;
    end
    cnt_nxt = issue ? cnt_r + 2'd1 : cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_h_r    <= in_mode;
      side_h_r    <= in_vel_side;
      fwd_h_r     <= in_vel_fwd;
      rot_h_r     <= in_vel_rot;
      meas_h_r[0] <= in_angle_front;
      meas_h_r[1] <= in_angle_left;
      meas_h_r[2] <= in_angle_right;
      meas_h_r[3] <= in_angle_rear;
    end
  end

  // Rotation coefficients per wheel for the left and forward components.
  always_comb begin
    case (cnt_r)
      2'd0: begin
        coef_l = swk_pkg::COEF_103;
        coef_f = 18'sd0;
      end
      2'd1: begin
        coef_l = -swk_pkg::COEF_026;
        coef_f = -swk_pkg::COEF_965;
      end
      2'd2: begin
        coef_l = -swk_pkg::COEF_026;
        coef_f = swk_pkg::COEF_965;
      end
      default: begin
        coef_l = -swk_pkg::COEF_103;
        coef_f = 18'sd0;
      end
    endcase
    tag_c.wheel = cnt_r;
    tag_c.lock  = mode_h_r;
    tag_c.meas  = meas_h_r[cnt_r];
  end

  assign pl = rot_h_r * coef_l;
  assign pf = rot_h_r * coef_f;

  assign lr = ($signed(lq1_r) + QW'(128)) >>> 8;
  assign fr = ($signed(fq1_r) + QW'(128)) >>> 8;

  assign psl = l82_r * l82_r;
  assign psf = f82_r * f82_r;

  always_comb begin
    logic signed [XW-1:0] x0, y0;
    x0 = XW'(f83_r) <<< 16;
    y0 = XW'(l83_r) <<< 16;
    vec_nxt.n    = swk_pkg::SQW'(sql3_r) + swk_pkg::SQW'(sqf3_r);
    vec_nxt.r    = '0;
    vec_nxt.zero = (f83_r == '0) && (l83_r == '0);
    vec_nxt.tag  = tag3_r;
    if (f83_r < 0) begin
      if (l83_r >= 0) begin
        vec_nxt.x = y0;
        vec_nxt.y = -x0;
        vec_nxt.z = swk_pkg::QUARTER_TURN;
      end else begin
        vec_nxt.x = -y0;
        vec_nxt.y = x0;
        vec_nxt.z = -swk_pkg::QUARTER_TURN;
      end
    end else begin
      vec_nxt.x = x0;
      vec_nxt.y = y0;
      vec_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lq1_r  <= (QW'(side_h_r) <<< 16) + QW'(pl);
      fq1_r  <= (QW'(fwd_h_r) <<< 16) + QW'(pf);
      tag1_r <= tag_c;
      l82_r  <= lr[L8W-1:0];
      f82_r  <= fr[L8W-1:0];
      tag2_r <= tag1_r;
      sql3_r <= unsigned'(psl);
      sqf3_r <= unsigned'(psf);
      l83_r  <= l82_r;
      f83_r  <= f82_r;
      tag3_r <= tag2_r;
      vec_r  <= vec_nxt;
    end
  end

  assign vec_valid = v4_r;
  assign vec       = vec_r;

endmodule

`default_nettype wire

>>> hdl/swerve_wheel_kinematics.sv
// Swerve wheel kinematics top level: front end, vector cell chain, heading
// and fold stage, remainder-by-45 unit and output register.
// A request is held until its four wheels have issued, with its four wheel
// results back to back; the single wheel lane through the cell chain takes
// one wheel per cycle unless a finished result is held by out_stall.
// Reset: synchronous on rst_n, clears the valid bits and the sequencer only.
`default_nettype none

module swerve_wheel_kinematics #(
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int CORDIC_STEPS    = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_mode,
  input  wire logic signed [15:0] in_vel_side,
  input  wire logic signed [15:0] in_vel_fwd,
  input  wire logic signed [15:0] in_vel_rot,
  input  wire logic signed [31:0] in_angle_front,
  input  wire logic signed [31:0] in_angle_left,
  input  wire logic signed [31:0] in_angle_right,
  input  wire logic signed [31:0] in_angle_rear,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_wheel,
  output logic [15:0]             out_speed,
  output logic signed [31:0]      out_target_angle,
  output logic                    out_reverse,
  output logic                    out_last
);

  localparam int AW  = swk_pkg::AW;
  localparam int DW  = swk_pkg::DW;
  localparam int ZW  = swk_pkg::ZW;
  localparam int SQW = swk_pkg::SQW;
  localparam int NV  = swk_pkg::SQ_STEPS;
  localparam int HS  = swk_pkg::Z_BITS - ANGLE_FRAC_BITS;
  localparam int FS  = ANGLE_FRAC_BITS + 2;

  localparam logic signed [AW-1:0] LOCK_R  = AW'(83) <<< ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] OFS     = AW'(100) <<< ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] MASK_LO = (AW'(1) <<< FS) - AW'(1);
  localparam logic signed [AW-1:0] TMAX    = (AW'(1) <<< 31) - AW'(1);
  localparam logic signed [AW-1:0] TMIN    = -(AW'(1) <<< 31);
  localparam logic [DW-1:0]        DIV_OFS = DW'(45) << (AW - 1);

  logic en;
  logic              vv_s [NV+1];
  swk_pkg::swk_vec_t vec_s [NV+1];
  logic              dv_s [2];
  swk_pkg::swk_div_t div_s [2];

  logic              hv_r;
  swk_pkg::swk_div_t hd_r, hd_nxt;

  logic              out_valid_r;
  logic [1:0]        wheel_r;
  logic [15:0]       speed_r;
  logic signed [31:0] target_r;
  logic              reverse_r, last_r;
  logic signed [31:0] target_nxt;

  // The whole lane moves together unless a finished result is held.
  assign en = !(out_valid_r && out_stall);

  swk_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_vel_side    (in_vel_side),
    .in_vel_fwd     (in_vel_fwd),
    .in_vel_rot     (in_vel_rot),
    .in_angle_front (in_angle_front),
    .in_angle_left  (in_angle_left),
    .in_angle_right (in_angle_right),
    .in_angle_rear  (in_angle_rear),
    .vec_valid      (vv_s[0]),
    .vec            (vec_s[0])
  );

  for (genvar g = 0; g < NV; g++) begin : g_vec
    swk_vec_cell #(
      .IDX          (g),
      .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (vv_s[g]),
      .in_vec    (vec_s[g]),
      .out_valid (vv_s[g+1]),
      .out_vec   (vec_s[g+1])
    );
  end

  // Heading rounding, speed rounding, and the fold of the angle error into
  // a dividend for the remainder-by-45 unit (the power-of-two part is a shift).
  always_comb begin
    swk_pkg::swk_vec_t         v;
    logic signed [ZW-1:0]      zr;
    logic signed [AW-1:0]      head, a, d;
    logic [SQW-1:0]            rs;
    v    = vec_s[NV];
    zr   = ($signed(v.z) + (ZW'(1) <<< (HS - 1))) >>> HS;
    head = AW'(zr);
    if (v.tag.lock) begin
      case (v.tag.wheel)
        2'd1:    head = -LOCK_R;
        2'd2:    head = LOCK_R;
        default: head = '0;
      endcase
    end else if (v.zero) begin
      head = '0;
    end
    rs = v.r + SQW'(128);
    if (v.tag.lock) begin
      hd_nxt.speed = '0;
    end else if (|rs[SQW-1:24]) begin
      hd_nxt.speed = 16'hFFFF;
    end else begin
      hd_nxt.speed = rs[23:8];
    end
    a           = AW'($signed(v.tag.meas)) - head + OFS;
    d           = a >>> FS;
    hd_nxt.num  = DW'(d) + DIV_OFS;
    hd_nxt.rem  = '0;
    hd_nxt.qbit = 1'b0;
    hd_nxt.lo   = a[swk_pkg::LOW-1:0];
    hd_nxt.tag  = v.tag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else if (en) begin
      hv_r <= vv_s[NV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hd_r <= hd_nxt;
    end
  end

  assign dv_s[0]  = hv_r;
  assign div_s[0] = hd_r;

  swk_div_cell u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_s[0]),
    .in_div    (div_s[0]),
    .out_valid (dv_s[1]),
    .out_div   (div_s[1])
  );

  // Target is measured + 100 deg - remainder, remainder rebuilt from the
  // remainder by 45 and the shifted-out low bits.
  always_comb begin
    swk_pkg::swk_div_t    q;
    logic signed [AW-1:0] r, t;
    q = div_s[1];
    r = (AW'(q.rem) <<< FS) | (AW'(q.lo) & MASK_LO);
    t = AW'($signed(q.tag.meas)) + OFS - r;
    if (t > TMAX) begin
      target_nxt = TMAX[31:0];
    end else if (t < TMIN) begin
      target_nxt = TMIN[31:0];
    end else begin
      target_nxt = t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_s[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wheel_r   <= div_s[1].tag.wheel;
      speed_r   <= div_s[1].speed;
      target_r  <= target_nxt;
      reverse_r <= div_s[1].qbit;
      last_r    <= (div_s[1].tag.wheel == 2'd3);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_wheel        = wheel_r;
  assign out_speed        = speed_r;
  assign out_target_angle = target_r;
  assign out_reverse      = reverse_r;
  assign out_last         = last_r;

  // The four wheels of one request leave in order with no gaps.
  a_wheel_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && (out_wheel == $past(out_wheel) + 2'd1)))
    else $error("wheel results out of order");

  // After a request is taken the sequencer holds off the next one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while wheels still issuing");

  // A result marked last is always the rear wheel.
  a_last_rear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_wheel == 2'd3)))
    else $error("last flag does not match rear wheel");

endmodule

`default_nettype wire
